@@ hdl/sdremap_pkg.sv @@
// Package for the sparse-to-dense identifier remap unit.
// Holds table sizes, command and status codes, and the beat and control structs.
// No dependencies.
package sdremap_pkg;

   localparam int GLOBAL_ENTRIES = 4096;
   localparam int LOCAL_ENTRIES  = 1024;

   localparam int GLB_AW = $clog2(GLOBAL_ENTRIES);
   localparam int LOC_AW = $clog2(LOCAL_ENTRIES);
   localparam int CNT_W  = 10;
   localparam int GID_W  = 12;
   localparam int CNT_LIMIT = (LOCAL_ENTRIES - 1 > 1023) ? 1023 : LOCAL_ENTRIES - 1;

   localparam logic [1:0] CMD_MAP     = 2'd0;
   localparam logic [1:0] CMD_REVERSE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [1:0] ST_FOUND = 2'd0;
   localparam logic [1:0] ST_NEW   = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [1:0]       command;
      logic [GID_W-1:0] global_index;
      logic [CNT_W-1:0] local_index;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] local_result;
      logic [GID_W-1:0] global_result;
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rev_rd;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

@@ hdl/sparse_to_dense_id_remap_unit.sv @@
// Sparse-to-dense identifier remap unit: hands out local numbers 1, 2, 3 and so
// on to global identifiers in order of first use and keeps the reverse map.
// Request beat on req_valid/req_stall/req_data, result beat on
// rsp_valid/rsp_stall/rsp_data; exactly one result beat per request beat.
// A request is taken only while the unit is idle, so one request is in flight.
// Map requests go from acceptance to the result register through a forward
// table read, a reverse table read at the local number found, then the commit
// of both tables and the counter. Reverse, clear and unknown commands skip
// the second read. The rate is set by these dependent reads of the two
// single-port table memories.
// The result register holds a finished beat while the receiver stalls; the
// unit then waits in its commit step until the register frees up, and it
// accepts the next request once that result is registered.
// Synchronous reset empties both maps at once by zeroing the counter; no
// table sweep is needed and a request may follow reset in the next cycle.
// Depends on sdremap_pkg, sdremap_ctrl and sdremap_dp.
module sparse_to_dense_id_remap_unit
   import sdremap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   sdremap_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_stall   (req_stall),
      .sts         (sts),
      .ctl         (ctl)
   );

   sdremap_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hdl/sdremap_ctrl.sv @@
// Sequencer for the remap unit: accepts a request and steps the datapath through
// its table reads and the final commit. Depends on sdremap_pkg.
module sdremap_ctrl
   import sdremap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   output logic       req_stall,
   input  sts_type    sts,
   output ctl_type    ctl
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_REV,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      ctl       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = (req_command == CMD_MAP) ? S_REV : S_FIN;
            end
         end
         S_REV: begin
            ctl.rev_rd = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!sts.out_busy) begin
               ctl.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/sdremap_dp.sv @@
// Datapath for the remap unit: forward and reverse tables, the local counter,
// the request hold registers and the result register. Depends on sdremap_pkg.
module sdremap_dp
   import sdremap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // A forward entry is trusted only if its local number is in use and the
   // reverse entry at that number points back, so clears need no sweep.
   logic [CNT_W-1:0] fwd_mem [GLOBAL_ENTRIES];
   logic [GID_W-1:0] rev_mem [LOCAL_ENTRIES];

   req_type          req_ff;
   logic [CNT_W-1:0] fwd_q_ff;
   logic [GID_W-1:0] rev_q_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic [LOC_AW-1:0] rev_addr;
   logic [CNT_W-1:0]  cnt_n;
   logic              fwd_hit;
   logic              fwd_we, rev_we;

   assign rev_addr = ctl.load ? LOC_AW'(req_data.local_index) : LOC_AW'(fwd_q_ff);
   assign cnt_n    = cnt_ff + CNT_W'(1);
   assign fwd_hit  = (req_ff.global_index != '0) && (fwd_q_ff != '0)
                     && (fwd_q_ff <= cnt_ff) && (rev_q_ff == req_ff.global_index);

   always_comb begin
      rsp_in = '0;
      rsp_in.status = ST_NONE;
      cnt_in = cnt_ff;
      fwd_we = 1'b0;
      rev_we = 1'b0;
      case (req_ff.command)
         CMD_MAP: begin
            if (fwd_hit) begin
               rsp_in.local_result = fwd_q_ff;
               rsp_in.status       = ST_FOUND;
            end else if (cnt_ff >= CNT_W'(CNT_LIMIT)) begin
               rsp_in.status = ST_FULL;
            end else begin
               cnt_in = cnt_n;
               rev_we = ctl.finish;
               if (req_ff.global_index != '0) begin
                  fwd_we              = ctl.finish;
                  rsp_in.local_result = cnt_n;
                  rsp_in.status       = ST_NEW;
               end
            end
         end
         CMD_REVERSE: begin
            if ((req_ff.local_index != '0) && (req_ff.local_index <= cnt_ff)
                && (rev_q_ff != '0)) begin
               rsp_in.global_result = rev_q_ff;
               rsp_in.status        = ST_FOUND;
            end
         end
         CMD_CLEAR: begin
            cnt_in        = '0;
            rsp_in.status = ST_FOUND;
         end
         default: begin
            rsp_in.status = ST_NONE;
         end
      endcase
      rsp_in.count = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (fwd_we) begin
         fwd_mem[GLB_AW'(req_ff.global_index)] <= cnt_n;
      end
      if (ctl.load) begin
         fwd_q_ff <= fwd_mem[GLB_AW'(req_data.global_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (rev_we) begin
         rev_mem[LOC_AW'(cnt_n)] <= req_ff.global_index;
      end
      if (ctl.load || ctl.rev_rd) begin
         rev_q_ff <= rev_mem[rev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.finish) begin
            cnt_ff       <= cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.out_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

endmodule

@@ hdl/sdremap_chk.sv @@
// Port-level checker for the remap unit, bound to the top level.
// Depends on sdremap_pkg and sparse_to_dense_id_remap_unit.
module sdremap_chk
   import sdremap_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result beat changed.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Second request taken while one is in flight.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_FULL) |-> rsp_data.count == CNT_W'(CNT_LIMIT))
      else $error("Full status reported below the count limit.");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_NEW)
      |-> (rsp_data.local_result == rsp_data.count) && (rsp_data.local_result != '0))
      else $error("Newly assigned number does not match the count.");

endmodule

bind sparse_to_dense_id_remap_unit sdremap_chk u_sdremap_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
